### src/nwm_pkg.sv
package nwm_pkg;

  localparam int NAME_MAX = 64;
  localparam int ENTRIES  = 64;
  localparam int KEEP_MAX = NAME_MAX - 1;
  localparam int SLOTS    = 2 * ENTRIES;
  localparam int IDX_W    = $clog2(NAME_MAX);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int PADDR_W  = $clog2(SLOTS * NAME_MAX);

  typedef enum logic [1:0] {
    MODE_BEGIN  = 2'd0,
    MODE_PAT    = 2'd1,
    MODE_COMMIT = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_QUERY  = 1'b0,
    KIND_COMMIT = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN_RD,
    ST_LEN_CHK,
    ST_CHR_RD,
    ST_CHR_CHK,
    ST_DONE
  } state_t;

  function automatic logic [7:0] lower_byte(input logic [7:0] c);
    lower_byte = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

### src/nwm_req_if.sv
interface nwm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_code;
  logic       last;

  modport source(output valid, mode, char_code, last, input ready);
  modport sink(input valid, mode, char_code, last, output ready);
endinterface

### src/nwm_rsp_if.sv
interface nwm_rsp_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic exact_hit;
  logic substring_hit;
  logic status;

  modport source(output valid, result_kind, exact_hit, substring_hit, status, input ready);
  modport sink(input valid, result_kind, exact_hit, substring_hit, status, output ready);
endinterface

### src/name_whitelist_matcher.sv
// channel | dir | payload                                        | transfer when
// req     | in  | mode, char_code, last                          | valid && ready
// rsp     | out | result_kind, exact_hit, substring_hit, status  | valid && ready
//
// begin, pattern, commit and non-final query characters are taken while idle, with no walk.
// a final query character starts a walk over the active patterns through one
// shared byte comparator: a length read and check per pattern, then a read and
// a check per compared byte. a pattern of len against a trimmed key of k <= 63
// bytes compares at most (k - len + 1) * len <= 32 * 32 bytes; after the last
// pattern the walk finishes and emits its result.
// rst is synchronous; the table comes up empty, no clearing pass.
// req is held off during the walk and while an unread result blocks the
// output register.
module name_whitelist_matcher (
  input  logic      clk,
  input  logic      rst,
  nwm_req_if.sink   req,
  nwm_rsp_if.source rsp
);

  localparam int IW = nwm_pkg::IDX_W;
  localparam int CW = nwm_pkg::CNT_W;
  localparam int SW = nwm_pkg::SLOT_W;
  localparam int AW = nwm_pkg::PADDR_W;

  nwm_pkg::state_t state, state_next;

  // table control
  logic          bank;
  logic [CW-1:0] act_cnt;
  logic [CW-1:0] sh_cnt;
  logic          sh_ovf;
  logic [IW-1:0] pend;

  // key buffer control, trim bounds tracked as characters arrive
  logic [IW-1:0] key_len;
  logic [IW-1:0] lead;
  logic          lead_done;
  logic [IW-1:0] tail_end;

  // walk registers
  logic [CW-1:0] ent;
  logic [IW-1:0] plen;
  logic [IW-1:0] pos;
  logic [IW-1:0] j;
  logic          ex;
  logic          sb;

  // output register
  logic out_valid, out_kind, out_ex, out_sb, out_st;
  logic out_load;

  // memories
  logic [7:0]    pat_mem [nwm_pkg::SLOTS * nwm_pkg::NAME_MAX];
  logic [IW-1:0] len_mem [nwm_pkg::SLOTS];
  logic [7:0]    key_mem [nwm_pkg::NAME_MAX];
  logic [7:0]    pat_q, key_q;
  logic [IW-1:0] len_q;
  logic [AW-1:0] pat_raddr, pat_waddr;
  logic [SW-1:0] len_raddr, wslot;
  logic [IW-1:0] key_raddr;

  logic            acc;
  nwm_pkg::mode_t  mode;
  logic [7:0]      c_low;
  logic            c_space;
  logic            pend_keep, key_keep, sh_full;
  logic [IW-1:0]   pend_inc;
  logic [IW-1:0]   key_k;
  logic            chr_eq, last_j, next_pos_ok;

  assign acc       = req.valid && req.ready;
  assign mode      = nwm_pkg::mode_t'(req.mode);
  assign c_low     = nwm_pkg::lower_byte(req.char_code);
  assign c_space   = nwm_pkg::is_space(c_low);
  assign pend_keep = pend < IW'(nwm_pkg::KEEP_MAX);
  assign key_keep  = key_len < IW'(nwm_pkg::KEEP_MAX);
  assign pend_inc  = pend + IW'(pend_keep);
  assign sh_full   = sh_cnt >= CW'(nwm_pkg::ENTRIES);
  assign key_k     = lead_done ? tail_end - lead : '0;

  // output register takes a new result this cycle
  assign out_load  = (acc && mode == nwm_pkg::MODE_COMMIT) ||
                     (state == nwm_pkg::ST_DONE && (!out_valid || rsp.ready));

  // shadow slot being filled, and its byte address
  assign wslot     = SW'(~bank) * SW'(nwm_pkg::ENTRIES) + SW'(sh_cnt);
  assign pat_waddr = AW'(wslot) * AW'(nwm_pkg::NAME_MAX) + AW'(pend);

  // walk compare results
  assign chr_eq      = pat_q == key_q;
  assign last_j      = j == plen - IW'(1);
  assign next_pos_ok = ({1'b0, pos} + {1'b0, plen}) < {1'b0, key_k};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      nwm_pkg::ST_IDLE: begin
        if (acc && mode == nwm_pkg::MODE_QUERY && req.last) state_next = nwm_pkg::ST_LEN_RD;
      end
      nwm_pkg::ST_LEN_RD: begin
        state_next = (ent >= act_cnt) ? nwm_pkg::ST_DONE : nwm_pkg::ST_LEN_CHK;
      end
      nwm_pkg::ST_LEN_CHK: begin
        if (len_q == '0 || len_q > key_k) state_next = nwm_pkg::ST_LEN_RD;
        else state_next = nwm_pkg::ST_CHR_RD;
      end
      nwm_pkg::ST_CHR_RD: begin
        state_next = nwm_pkg::ST_CHR_CHK;
      end
      nwm_pkg::ST_CHR_CHK: begin
        if (chr_eq && !last_j) state_next = nwm_pkg::ST_CHR_RD;
        else if (!chr_eq && next_pos_ok) state_next = nwm_pkg::ST_CHR_RD;
        else state_next = nwm_pkg::ST_LEN_RD;
      end
      nwm_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) state_next = nwm_pkg::ST_IDLE;
      end
      default: state_next = nwm_pkg::ST_IDLE;
    endcase
  end

  // outputs and read addresses
  always_comb begin
    req.ready = (state == nwm_pkg::ST_IDLE) && (!out_valid || rsp.ready);
    len_raddr = SW'(bank) * SW'(nwm_pkg::ENTRIES) + SW'(ent);
    pat_raddr = AW'(len_raddr) * AW'(nwm_pkg::NAME_MAX) + AW'(j);
    key_raddr = IW'({1'b0, lead} + {1'b0, pos} + {1'b0, j});
  end

  assign rsp.valid         = out_valid;
  assign rsp.result_kind   = out_kind;
  assign rsp.exact_hit     = out_ex;
  assign rsp.substring_hit = out_sb;
  assign rsp.status        = out_st;

  // memories
  always_ff @(posedge clk) begin
    if (acc && mode == nwm_pkg::MODE_PAT && pend_keep && !sh_full)
      pat_mem[pat_waddr] <= c_low;
    if (acc && mode == nwm_pkg::MODE_PAT && req.last && pend_inc != '0 && !sh_full)
      len_mem[wslot] <= pend_inc;
    if (acc && mode == nwm_pkg::MODE_QUERY && key_keep)
      key_mem[key_len] <= c_low;
    pat_q <= pat_mem[pat_raddr];
    len_q <= len_mem[len_raddr];
    key_q <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nwm_pkg::ST_IDLE;
      bank      <= 1'b0;
      act_cnt   <= '0;
      sh_cnt    <= '0;
      sh_ovf    <= 1'b0;
      pend      <= '0;
      key_len   <= '0;
      lead      <= '0;
      lead_done <= 1'b0;
      tail_end  <= '0;
      ent       <= '0;
      ex        <= 1'b0;
      sb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && rsp.ready && !out_load) out_valid <= 1'b0;

      if (acc) begin
        case (mode)
          nwm_pkg::MODE_BEGIN: begin
            sh_cnt <= '0;
            sh_ovf <= 1'b0;
            pend   <= '0;
          end
          nwm_pkg::MODE_PAT: begin
            if (req.last) begin
              pend <= '0;
              if (pend_inc != '0) begin
                if (!sh_full) sh_cnt <= sh_cnt + CW'(1);
                else sh_ovf <= 1'b1;
              end
            end else begin
              pend <= pend_inc;
            end
          end
          nwm_pkg::MODE_COMMIT: begin
            out_valid <= 1'b1;
            out_kind  <= nwm_pkg::KIND_COMMIT;
            out_ex    <= 1'b0;
            out_sb    <= 1'b0;
            out_st    <= sh_ovf;
            if (!sh_ovf) begin
              bank    <= ~bank;
              act_cnt <= sh_cnt;
            end
            sh_cnt <= '0;
            sh_ovf <= 1'b0;
            pend   <= '0;
          end
          default: begin
            if (key_keep) begin
              key_len <= key_len + IW'(1);
              if (!lead_done) begin
                if (c_space) lead <= lead + IW'(1);
                else lead_done <= 1'b1;
              end
              if (!c_space) tail_end <= key_len + IW'(1);
            end
            if (req.last) begin
              ent <= '0;
              ex  <= 1'b0;
              sb  <= 1'b0;
            end
          end
        endcase
      end

      case (state)
        nwm_pkg::ST_LEN_CHK: begin
          plen <= len_q;
          pos  <= '0;
          j    <= '0;
          if (len_q == '0 || len_q > key_k) ent <= ent + CW'(1);
        end
        nwm_pkg::ST_CHR_CHK: begin
          if (chr_eq && !last_j) begin
            j <= j + IW'(1);
          end else if (chr_eq) begin
            // whole pattern matched at this offset
            sb  <= 1'b1;
            if (plen == key_k) ex <= 1'b1;
            ent <= ent + CW'(1);
          end else if (next_pos_ok) begin
            pos <= pos + IW'(1);
            j   <= '0;
          end else begin
            ent <= ent + CW'(1);
          end
        end
        nwm_pkg::ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_kind  <= nwm_pkg::KIND_QUERY;
            out_ex    <= ex;
            out_sb    <= sb;
            out_st    <= 1'b0;
            key_len   <= '0;
            lead      <= '0;
            lead_done <= 1'b0;
            tail_end  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### src/nwm_checker.sv
module nwm_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [1:0] req_mode,
  input logic       req_last,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_result_kind,
  input logic       rsp_exact_hit,
  input logic       rsp_substring_hit,
  input logic       rsp_status
);

  // result waits until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp dropped before transfer");

  // a commit answers in the next cycle with a commit status
  a_commit_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_mode == nwm_pkg::MODE_COMMIT
    |=> rsp_valid && rsp_result_kind == nwm_pkg::KIND_COMMIT)
    else $error("commit status missing");

  // final query character starts the walk, input held off
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_mode == nwm_pkg::MODE_QUERY && req_last
    |=> !req_ready)
    else $error("accepting input during walk");

  // field usage per kind
  a_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_result_kind == nwm_pkg::KIND_QUERY ? !rsp_status
                   : (!rsp_exact_hit && !rsp_substring_hit)))
    else $error("field set in wrong result kind");

  // an exact hit is also a substring hit
  a_exact_sub: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_exact_hit |-> rsp_substring_hit)
    else $error("exact hit without substring hit");

endmodule

bind name_whitelist_matcher nwm_checker u_nwm_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .req_mode          (req.mode),
  .req_last          (req.last),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_result_kind   (rsp.result_kind),
  .rsp_exact_hit     (rsp.exact_hit),
  .rsp_substring_hit (rsp.substring_hit),
  .rsp_status        (rsp.status)
);
